>>> hw/rtl/yuv420_to_yuv444_planar_assert.svh
// Assertion macros for the 4:2:0 to 4:4:4 converter.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef YUV420_TO_YUV444_PLANAR_ASSERT_SVH
`define YUV420_TO_YUV444_PLANAR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define Y2Y_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define Y2Y_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define Y2Y_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define Y2Y_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/y2y_pkg.sv
// Shared types and constants of the 4:2:0 to 4:4:4 converter.
// No dependencies.
package y2y_pkg;

  localparam int BYTE_W          = 8;
  localparam int WIDTH_W         = 6;
  localparam int HEIGHT_W        = 12;
  localparam int COL_W           = 5;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 12;
  localparam int MAX_WIDTH_DEF   = 62;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 6'd6;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  localparam logic [1:0] KIND_LUMA    = 2'd0;
  localparam logic [1:0] KIND_CHROMA  = 2'd1;
  localparam logic [1:0] KIND_ROW_END = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [1:0]         kind;
    logic [COL_W-1:0]   col;
    logic [WIDTH_W-1:0] width;
    logic               frame_done;
  } item_t;

endpackage

>>> hw/rtl/y2y_if.sv
// Channel interfaces: 4:2:0 input bytes, 4:4:4 output bytes, register writes.
// Depends on y2y_pkg.
interface y2y_in_if;
  logic                      valid;
  logic                      ready;
  logic [y2y_pkg::BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface y2y_out_if;
  logic                      valid;
  logic                      ready;
  logic [y2y_pkg::BYTE_W-1:0] out_byte;
  logic                      last;
  logic                      frame_end;
  modport source (output valid, output out_byte, output last, output frame_end, input ready);
  modport sink (input valid, input out_byte, input last, input frame_end, output ready);
endinterface

interface y2y_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [y2y_pkg::CFG_IDX_W-1:0]  index;
  logic [y2y_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/y2y_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on y2y_pkg.
module y2y_queue #(
  parameter int DEPTH = y2y_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  y2y_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output y2y_pkg::item_t pop_item
);
  import y2y_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/y2y_front.sv
// Front end: config registers, plane/row/column tracking, item classification.
// Depends on y2y_pkg and y2y_if.
module y2y_front #(
  parameter int MAX_WIDTH = y2y_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  y2y_in_if.sink         stream420,
  y2y_cfg_if.sink        cfg,
  output logic           item_valid,
  input  logic           item_ready,
  output y2y_pkg::item_t item
);
  import y2y_pkg::*;

  localparam logic [WIDTH_W-1:0] WMAX = WIDTH_W'(MAX_WIDTH) & ~WIDTH_W'(1);

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [1:0]          plane_sel, plane_sel_next;
  logic [HEIGHT_W-1:0] row_count, row_count_next;
  logic [WIDTH_W-1:0]  col_count, col_count_next;

  logic [WIDTH_W-1:0]  w_raw, w_eff, half, c;
  logic [HEIGHT_W-1:0] h_raw, h_eff, rows, r;
  logic                is_v, row_end, acc;

  assign cfg.ready       = 1'b1;
  assign stream420.ready = item_ready;
  assign item_valid      = stream420.valid;
  assign acc             = stream420.valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective geometry: rounded down to even, clamped to the legal range
  always_comb begin
    w_raw = frame_width & ~WIDTH_W'(1);
    if (w_raw > WMAX) begin
      w_eff = WMAX;
    end else if (w_raw < WIDTH_W'(2)) begin
      w_eff = WIDTH_W'(2);
    end else begin
      w_eff = w_raw;
    end
    h_raw = frame_height & ~HEIGHT_W'(1);
    h_eff = (h_raw < HEIGHT_W'(2)) ? HEIGHT_W'(2) : h_raw;
    half  = w_eff >> 1;
    rows  = h_eff >> 1;
  end

  always_comb begin
    plane_sel_next = plane_sel;
    row_count_next = row_count;
    col_count_next = col_count;
    is_v           = (plane_sel != PLANE_U);
    c              = col_count;
    r              = row_count;
    row_end        = 1'b0;
    if (plane_sel == PLANE_Y) begin
      c = (col_count >= w_eff) ? w_eff - 1'b1 : col_count;
      r = (row_count >= h_eff) ? h_eff - 1'b1 : row_count;
      if (c + 1'b1 >= w_eff) begin
        col_count_next = '0;
        if (r + 1'b1 >= h_eff) begin
          row_count_next = '0;
          plane_sel_next = PLANE_U;
        end else begin
          row_count_next = r + 1'b1;
        end
      end else begin
        col_count_next = c + 1'b1;
        row_count_next = r;
      end
    end else begin
      c       = (col_count >= half) ? half - 1'b1 : col_count;
      r       = (row_count >= rows) ? rows - 1'b1 : row_count;
      row_end = (c == half - 1'b1);
      if (row_end) begin
        col_count_next = '0;
        if (r + 1'b1 >= rows) begin
          row_count_next = '0;
          plane_sel_next = is_v ? PLANE_Y : PLANE_V;
        end else begin
          row_count_next = r + 1'b1;
        end
      end else begin
        col_count_next = c + 1'b1;
        row_count_next = r;
      end
    end
  end

  always_comb begin
    item.data       = stream420.in_byte;
    item.col        = c[COL_W-1:0];
    item.width      = w_eff;
    item.frame_done = (plane_sel != PLANE_Y) && is_v && (r == rows - 1'b1);
    if (plane_sel == PLANE_Y) begin
      item.kind = KIND_LUMA;
    end else if (row_end) begin
      item.kind = KIND_ROW_END;
    end else begin
      item.kind = KIND_CHROMA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_sel <= PLANE_Y;
      row_count <= '0;
      col_count <= '0;
    end else if (acc) begin
      plane_sel <= plane_sel_next;
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

>>> hw/rtl/y2y_back.sv
// Back end: chroma line buffer, doubling/replay sequencer, output register.
// Depends on y2y_pkg, y2y_if and the assertion macro header.
`include "yuv420_to_yuv444_planar_assert.svh"
module y2y_back #(
  parameter int MAX_WIDTH = y2y_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_pop,
  input  y2y_pkg::item_t item,
  y2y_out_if.source      stream444
);
  import y2y_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  logic [BYTE_W-1:0]  line [LINE_DEPTH];
  item_t              cur;
  logic               busy;
  logic [WIDTH_W-1:0] step;
  logic [WIDTH_W-1:0] rep;
  logic               o_valid;
  logic [BYTE_W-1:0]  o_byte;
  logic               o_last;
  logic               o_fe;

  logic               adv, fin, load;
  logic [BYTE_W-1:0]  r_byte;
  logic               r_fe;
  logic [WIDTH_W-1:0] nrep;
  logic [BYTE_W-1:0]  rd_byte;

  assign stream444.valid     = o_valid;
  assign stream444.out_byte  = o_byte;
  assign stream444.last      = o_last;
  assign stream444.frame_end = o_fe;

  assign rep  = step - WIDTH_W'(2);
  // replay position of the following step
  assign nrep = step - WIDTH_W'(1);

  // result for the current step; steps 0,1 are the doubled byte, then the replay
  always_comb begin
    r_byte = cur.data;
    r_fe   = 1'b0;
    fin    = 1'b0;
    case (cur.kind)
      KIND_LUMA: begin
        fin = 1'b1;
      end
      KIND_CHROMA: begin
        fin = (step == WIDTH_W'(1));
      end
      KIND_ROW_END: begin
        if (step >= WIDTH_W'(2)) begin
          r_byte = rd_byte;
          fin    = (rep == cur.width - 1'b1);
          r_fe   = fin && cur.frame_done;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  assign adv      = busy && (!o_valid || stream444.ready);
  assign load     = item_valid && (!busy || (adv && fin));
  assign item_pop = load;

  always_ff @(posedge clk) begin
    if (load && item.kind != KIND_LUMA) begin
      line[item.col] <= item.data;
    end
    // fetch the line entry one step ahead of its use
    if (adv && !fin && step != '0) begin
      rd_byte <= line[nrep[WIDTH_W-1:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item;
    end
    if (adv) begin
      o_byte <= r_byte;
      o_last <= fin;
      o_fe   <= r_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      step    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (adv) begin
        o_valid <= 1'b1;
      end else if (stream444.ready) begin
        o_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        step <= '0;
      end else if (adv && fin) begin
        busy <= 1'b0;
      end else if (adv) begin
        step <= step + 1'b1;
      end
    end
  end

  `Y2Y_ASSERT_NXT(a_load_starts, clk, rst, load, busy && step == '0, "no sequencer restart")
  `Y2Y_ASSERT_NXT(a_idle_after_fin, clk, rst, adv && fin && !item_valid, !busy, "sequencer stuck")
  `Y2Y_ASSERT_NXT(a_luma_single, clk, rst, adv && cur.kind == KIND_LUMA, o_valid && o_last, "luma")
  `Y2Y_ASSERT_IMP(a_fe_is_last, clk, rst, o_valid && o_fe, o_last, "frame end without last")

endmodule

>>> hw/rtl/yuv420_to_yuv444_planar.sv
// 4:2:0 planar to 4:4:4 planar converter, nearest chroma. A luma request gives one
// result, a chroma request two, and a request that ends a chroma row two plus a
// replay of width results; the back end emits one result per cycle unless stalled
// by the output, so rate is set by the output register. An accepted request reaches
// its first result via the queue, sequencer and output register. Synchronous reset
// clears counters, queue, sequencer and output valid; the line buffer is not reset.
module yuv420_to_yuv444_planar #(
  parameter int MAX_WIDTH   = y2y_pkg::MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = y2y_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  y2y_in_if.sink     stream420,
  y2y_out_if.source  stream444,
  y2y_cfg_if.sink    cfg
);
  import y2y_pkg::*;

  // front -> queue
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  // queue -> back
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  // Front end tracks plane, row and column and tags each request as luma,
  // chroma, or chroma row end; it stalls only when the queue is full.
  y2y_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .stream420  (stream420),
    .cfg        (cfg),
    .item_valid (push_valid),
    .item_ready (push_ready),
    .item       (push_item)
  );

  // Decouples classification from the long row replays.
  y2y_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // Back end stores chroma into the line buffer, doubles each byte and
  // replays the doubled row after the row end; the frame end flag rides on
  // the last replayed byte of the V plane.
  y2y_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_pop   (pop),
    .item       (pop_item),
    .stream444  (stream444)
  );

endmodule

>>> verif/y2y_upsample_checker.sv
// Scoreboard for the 4:2:0 to 4:4:4 converter: tracks register writes and input bytes,
// predicts every output byte with its last and frame_end flags, and compares in order.
// Depends on y2y_pkg and the channel interfaces in y2y_if.
module y2y_upsample_checker (
  input  logic clk,
  input  logic rst,
  y2y_in_if    stream420,
  y2y_out_if   stream444,
  y2y_cfg_if   cfg_bus,
  output int   mismatches,
  output int   expected_left,
  output int   bytes_checked,
  output int   frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import y2y_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH_DEF / 2;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] pix;
    logic              last;
    logic              frame_end;
  } pix444_t;

  pix444_t             pix444_q[$];
  pix444_t             held;
  bit                  have_held;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [1:0]          plane;
  logic [HEIGHT_W-1:0] row;
  logic [WIDTH_W-1:0]  col;
  logic [BYTE_W-1:0]   chroma_row [LINE_DEPTH];

  // Odd values round down, tiny values become two, oversize clamps to the buffer.
  function automatic int unsigned row_width();
    int unsigned w;
    w = 32'({width_reg[WIDTH_W-1:1], 1'b0});
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF & ~1;
    if (w < 2) w = 2;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = 32'({height_reg[HEIGHT_W-1:1], 1'b0});
    if (h < 2) h = 2;
    return h;
  endfunction

  // One byte is held back so the final byte of a request can get its last flag.
  function automatic void emit(input logic [BYTE_W-1:0] pix, input logic fend);
    if (have_held) pix444_q.push_back(held);
    held.pix       = pix;
    held.last      = 1'b0;
    held.frame_end = fend;
    have_held      = 1'b1;
  endfunction

  task automatic upsample_byte(input logic [BYTE_W-1:0] b);
    int unsigned w, h, half, rows, i;
    bit          is_v, plane_done;
    w = row_width();
    h = frame_rows();
    if (plane == PLANE_Y) begin
      if (col >= w) col = WIDTH_W'(w - 1);
      if (row >= h) row = HEIGHT_W'(h - 1);
      emit(b, 1'b0);
      col++;
      if (col >= w) begin
        col = '0;
        row++;
        if (row >= h) begin
          row   = '0;
          plane = PLANE_U;
        end
      end
    end else begin
      half = w >> 1;
      rows = h >> 1;
      is_v = (plane != PLANE_U);
      // counters past new bounds pin to the last column / row
      if (col >= half) col = WIDTH_W'(half - 1);
      if (row >= rows) row = HEIGHT_W'(rows - 1);
      chroma_row[col[COL_W-1:0]] = b;
      emit(b, 1'b0);
      emit(b, 1'b0);
      if (col == half - 1) begin
        plane_done = (row == rows - 1);
        for (i = 0; i < w; i++)
          emit(chroma_row[COL_W'(i >> 1)], is_v && plane_done && (i == w - 1));
        col = '0;
        row++;
        if (row >= rows) begin
          row   = '0;
          plane = is_v ? PLANE_Y : PLANE_V;
        end
      end else begin
        col++;
      end
    end
    held.last = 1'b1;
    pix444_q.push_back(held);
    have_held = 1'b0;
  endtask

  task automatic check_pix(input pix444_t got);
    pix444_t want;
    if (pix444_q.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("mismatch %0d at %0t: output byte %02h last %0b frame_end %0b, none expected",
                 mismatches, $time, got.pix, got.last, got.frame_end);
    end else begin
      want = pix444_q.pop_front();
      bytes_checked++;
      if (got.frame_end) frames_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display({"mismatch %0d at %0t: expected byte %02h last %0b frame_end %0b,",
                    " got %02h %0b %0b"},
                   mismatches, $time, want.pix, want.last, want.frame_end,
                   got.pix, got.last, got.frame_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg      = WIDTH_RESET;
      height_reg     = HEIGHT_RESET;
      plane          = PLANE_Y;
      row            = '0;
      col            = '0;
      have_held      = 1'b0;
      pix444_q.delete();
      mismatches     = 0;
      bytes_checked  = 0;
      frames_checked = 0;
    end else begin
      // outputs first: nothing legal can come out in the cycle its request goes in
      if (stream444.valid && stream444.ready)
        check_pix({stream444.out_byte, stream444.last, stream444.frame_end});
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == REG_FRAME_WIDTH)
          width_reg = cfg_bus.data[WIDTH_W-1:0];
        else if (cfg_bus.index == REG_FRAME_HEIGHT)
          height_reg = cfg_bus.data[HEIGHT_W-1:0];
      end
      if (stream420.valid && stream420.ready)
        upsample_byte(stream420.in_byte);
    end
    expected_left = pix444_q.size();
  end

endmodule

>>> verif/yuv420_to_yuv444_planar_tb.sv
// Top of the 4:2:0 to 4:4:4 converter testbench: clock, reset, register writes, input
// bytes with random gaps, output stalls and the verdict. Depends on y2y_pkg, y2y_if,
// the converter RTL and y2y_upsample_checker.
module yuv420_to_yuv444_planar_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import y2y_pkg::*;

  localparam int ITEM_TARGET   = 430;
  localparam int STALL_LIMIT   = 1000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 8;     // quiet cycles added once no result is owed
  // index outside the register map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

  logic clk = 1'b0;
  logic rst;

  y2y_in_if  stream420 ();
  y2y_out_if stream444 ();
  y2y_cfg_if cfg_bus ();

  int mismatch_count;
  int expected_left;
  int bytes_checked;
  int frames_checked;
  int items_sent;
  int reg_writes;
  int idle_cycles;
  int stall_left;
  bit calm;  // phase with no gaps on either side

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  yuv420_to_yuv444_planar DUT (
    .clk       (clk),
    .rst       (rst),
    .stream420 (stream420.sink),
    .stream444 (stream444.source),
    .cfg       (cfg_bus.sink)
  );

  y2y_upsample_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .stream420      (stream420),
    .stream444      (stream444),
    .cfg_bus        (cfg_bus),
    .mismatches     (mismatch_count),
    .expected_left  (expected_left),
    .bytes_checked  (bytes_checked),
    .frames_checked (frames_checked)
  );

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Output side back-pressure; a replay row can be stalled anywhere along its length.
  always @(posedge clk) begin
    int hold;
    if (stall_left > 0) begin
      stream444.ready <= 1'b0;
      stall_left--;
    end else begin
      hold = calm ? 0 : pick_gap();
      if (hold == 0) begin
        stream444.ready <= 1'b1;
      end else begin
        stream444.ready <= 1'b0;
        stall_left = hold - 1;
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    if (rst || (stream420.valid && stream420.ready) || (stream444.valid && stream444.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results still owed", STALL_LIMIT,
               expected_left);
      $display("yuv420_to_yuv444_planar_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input byte: optional gap with valid low, then hold valid until accepted.
  // Valid is left high on return so back-to-back bytes never drop it.
  task automatic send_pix(input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      stream420.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream420.valid   <= 1'b1;
    stream420.in_byte <= b;
    do @(posedge clk); while (!stream420.ready);
    items_sent++;
  endtask

  // Register write request; drops valid and waits for the next clock edge so the next
  // request never lowers and raises valid in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // Stop input and wait for every owed result, then a little longer so the
  // block is fully quiet before registers change.
  task automatic settle();
    stream420.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata);
    settle();
    write_reg(REG_FRAME_WIDTH, wdata);
    write_reg(REG_FRAME_HEIGHT, hdata);
  endtask

  initial begin
    int                    n, k, pick;
    bit                    big_done;
    logic [WIDTH_W-1:0]    w6, pad6;
    logic [CFG_DATA_W-1:0] wdata, hdata;

    // everything known from time zero
    rst               = 1'b1;
    stream420.valid   = 1'b0;
    stream420.in_byte = '0;
    stream444.ready   = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_FRAME_WIDTH;
    cfg_bus.data      = '0;
    stall_left        = 0;
    calm              = 1'b0;
    items_sent        = 0;
    reg_writes        = 0;
    big_done          = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // Odd width and height round down to 2x2: smallest full frame, 4 luma + 1 U + 1 V.
    // Byte extremes 00/FF on both luma and chroma; V replay carries frame_end.
    set_frame(12'd3, 12'd1);
    send_pix(8'h00); send_pix(8'hFF); send_pix(8'h80); send_pix(8'h7F);
    send_pix(8'hFF);
    send_pix(8'h00);

    // Zero width and odd height also land on 2x2.
    set_frame(12'd0, 12'd3);
    send_pix(8'h55); send_pix(8'hAA); send_pix(8'h01); send_pix(8'hFE);
    send_pix(8'h00);
    send_pix(8'hFF);

    // All data bits set: width 63 clamps to 62, height 4095 rounds to 4094.
    // Leave the first luma row partly done...
    set_frame(12'hFFF, 12'hFFF);
    for (k = 0; k < 5; k++) send_pix(BYTE_W'(8'h10 * k + 8'h0F));
    // ...then shrink mid-frame: the column pins to the last one and the next
    // byte closes the row; the row count is then inside a 2-row frame.
    set_frame(12'd4, 12'd2);
    for (k = 0; k < 9; k++) send_pix(BYTE_W'(8'hF0 - 8'h11 * k));

    // ---- random phases ----
    // Phases stop at arbitrary points, so later register changes land mid-row
    // and mid-plane in every plane; saturation is exercised throughout.
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      if (!big_done && items_sent > 120) begin
        // full-width 2-row frame: each chroma row end gives 64 results
        set_frame(12'd62, 12'd2);
        n        = 186;
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0:       w6 = WIDTH_W'($urandom_range(0, 63));
          1:       w6 = WIDTH_W'($urandom_range(58, 63));
          default: w6 = WIDTH_W'($urandom_range(2, 16));
        endcase
        pad6  = WIDTH_W'($urandom_range(0, 63));
        wdata = {pad6, w6};
        case ($urandom_range(0, 9))
          0:       hdata = CFG_DATA_W'($urandom_range(0, 3));
          1:       hdata = CFG_DATA_W'($urandom_range(4088, 4095));
          default: hdata = CFG_DATA_W'($urandom_range(2, 7));
        endcase
        if (hdata > 12'd64)      n = $urandom_range(10, 30);
        else if (w6 > 6'd32)     n = $urandom_range(20, 70);
        else                     n = $urandom_range(8, 50);

        settle();
        pick = $urandom_range(0, 5);
        if (pick != 1) write_reg(REG_FRAME_WIDTH, wdata);
        if (pick != 0) write_reg(REG_FRAME_HEIGHT, hdata);
        if ($urandom_range(0, 7) == 0)
          write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 4095)));
      end
      repeat (n) send_pix(BYTE_W'($urandom_range(0, 255)));
    end

    calm = 1'b0;
    settle();

    $display("Run: %0d input bytes and %0d register writes, %0d output bytes compared",
             items_sent, reg_writes, bytes_checked);
    $display("Run: %0d frame ends seen, widths 2..62, heights 2..4094, mid-frame changes",
             frames_checked);
    if (mismatch_count == 0) begin
      $display("yuv420_to_yuv444_planar_tb passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("yuv420_to_yuv444_planar_tb failed");
    end
    $finish;
  end

endmodule
